>>> rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, constants and the bracket pair lookup of the script run
// segmenter.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int PAIR_TABLE_SIZE = 116;
  localparam int PAIR_W          = 7;
  localparam int SCRIPT_W        = 8;
  localparam int CP_W            = 21;
  localparam int LEN_W           = 16;

  typedef logic [SCRIPT_W-1:0] scr_code_t;
  typedef logic [PAIR_W-1:0]   pair_t;

  typedef struct packed {
    logic  found;
    pair_t idx;
  } bracket_t;

  localparam logic [15:0] BRACKET_TAB [PAIR_TABLE_SIZE] = '{
    16'h0028, 16'h0029, 16'h003c, 16'h003e, 16'h005b, 16'h005d, 16'h007b, 16'h007d,
    16'h00ab, 16'h00bb, 16'h0f3a, 16'h0f3b, 16'h0f3c, 16'h0f3d, 16'h169b, 16'h169c,
    16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2039, 16'h203a, 16'h2045, 16'h2046,
    16'h207d, 16'h207e, 16'h208d, 16'h208e, 16'h27e6, 16'h27e7, 16'h27e8, 16'h27e9,
    16'h27ea, 16'h27eb, 16'h27ec, 16'h27ed, 16'h27ee, 16'h27ef, 16'h2983, 16'h2984,
    16'h2985, 16'h2986, 16'h2987, 16'h2988, 16'h2989, 16'h298a, 16'h298b, 16'h298c,
    16'h298d, 16'h298e, 16'h298f, 16'h2990, 16'h2991, 16'h2992, 16'h2993, 16'h2994,
    16'h2995, 16'h2996, 16'h2997, 16'h2998, 16'h29fc, 16'h29fd, 16'h2e02, 16'h2e03,
    16'h2e04, 16'h2e05, 16'h2e09, 16'h2e0a, 16'h2e0c, 16'h2e0d, 16'h2e1c, 16'h2e1d,
    16'h2e20, 16'h2e21, 16'h2e22, 16'h2e23, 16'h2e24, 16'h2e25, 16'h2e26, 16'h2e27,
    16'h2e28, 16'h2e29, 16'h3008, 16'h3009, 16'h300a, 16'h300b, 16'h300c, 16'h300d,
    16'h300e, 16'h300f, 16'h3010, 16'h3011, 16'h3014, 16'h3015, 16'h3016, 16'h3017,
    16'h3018, 16'h3019, 16'h301a, 16'h301b, 16'hfe59, 16'hfe5a, 16'hfe5b, 16'hfe5c,
    16'hfe5d, 16'hfe5e, 16'hff08, 16'hff09, 16'hff3b, 16'hff3d, 16'hff5b, 16'hff5d,
    16'hff5f, 16'hff60, 16'hff62, 16'hff63
  };

  function automatic bracket_t lookup_bracket(input logic [CP_W-1:0] cp);
    bracket_t res;
    res = '0;
    for (int i = 0; i < PAIR_TABLE_SIZE; i++) begin
      if (cp[CP_W-1:16] == '0 && cp[15:0] == BRACKET_TAB[i]) begin
        res.found = 1'b1;
        res.idx   = PAIR_W'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/srs_stack_mem.sv
// ----------------------------------------------------------------------------
// srs_stack_mem
// Bracket stack storage: pair index and script memories with one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module srs_stack_mem #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             pair_we,
  input  logic                             script_we,
  input  logic [$clog2(STACK_DEPTH)-1:0]   wr_addr,
  input  srs_pkg::pair_t                   wr_pair,
  input  srs_pkg::scr_code_t               wr_script,
  input  logic [$clog2(STACK_DEPTH)-1:0]   rd_addr,
  output srs_pkg::pair_t                   rd_pair,
  output srs_pkg::scr_code_t               rd_script
);
  import srs_pkg::*;

  pair_t     pair_mem   [STACK_DEPTH];
  scr_code_t script_mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[wr_addr] <= wr_pair;
    end
    if (script_we) begin
      script_mem[wr_addr] <= wr_script;
    end
    rd_pair   <= pair_mem[rd_addr];
    rd_script <= script_mem[rd_addr];
  end

endmodule

>>> rtl/script_run_segmenter.sv
// ----------------------------------------------------------------------------
// script_run_segmenter
// Splits a code point stream into script runs, resolving paired brackets
// through a bracket stack held in memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  code_point, char_script, end_of_text
// out       source     out_valid/out_stall  run_script, run_units, final_run
// config    APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// A request is accepted in the idle state and evaluate, decide and finish follow. A
// closing bracket on a nonempty stack passes the pop state once per entry read from
// the stack top, and each stacked bracket given a new script passes the fill state once.
// End of text adds an emit state for the final result; a script break adds one for
// the result plus a second pass. Reset is synchronous; the stack needs no clearing pass.
// A result waits in the output register while the next request is accepted; a second
// result stalls the sequencer until the register is free.
// ----------------------------------------------------------------------------
module script_run_segmenter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [20:0]            code_point,
  input  srs_pkg::scr_code_t     char_script,
  input  logic                   end_of_text,
  output logic                   out_valid,
  input  logic                   out_stall,
  output srs_pkg::scr_code_t     run_script,
  output logic [15:0]            run_units,
  output logic                   final_run,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import srs_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_EMITB  = 3'd6;
  localparam logic [2:0] S_EMITF  = 3'd7;

  localparam logic REG_COMMON    = 1'b0;
  localparam logic REG_INHERITED = 1'b1;

  scr_code_t common_code, inherited_code;
  logic [2:0] state, state_next;
  scr_code_t running, running_next;
  logic [LEN_W-1:0] length, length_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] mark, mark_next;
  scr_code_t scr, scr_next;
  pair_t pidx;
  logic is_open, is_close, eot, two_units;
  scr_code_t cs;

  logic pair_we, script_we;
  logic [AW-1:0] wr_addr, rd_addr;
  scr_code_t wr_script, rd_script;
  pair_t rd_pair;

  logic load_out, load_final;
  bracket_t br;
  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [LEN_W:0] len_sum;
  logic rr, r, out_free;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_INHERITED) ? {24'd0, inherited_code} : {24'd0, common_code};
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign br       = lookup_bracket(code_point);
  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign rr       = (running != common_code) && (running != inherited_code);
  assign r        = (scr != common_code) && (scr != inherited_code);
  assign len_sum  = {1'b0, length} + (two_units ? 17'd2 : 17'd1);

  srs_stack_mem #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk       (clk),
    .pair_we   (pair_we),
    .script_we (script_we),
    .wr_addr   (wr_addr),
    .wr_pair   (pidx),
    .wr_script (wr_script),
    .rd_addr   (rd_addr),
    .rd_pair   (rd_pair),
    .rd_script (rd_script)
  );

  always_comb begin
    state_next   = state;
    running_next = running;
    length_next  = length;
    count_next   = count;
    mark_next    = mark;
    scr_next     = scr;
    pair_we      = 1'b0;
    script_we    = 1'b0;
    wr_addr      = count[AW-1:0];
    wr_script    = running;
    rd_addr      = cnt_m1[AW-1:0];
    load_out     = 1'b0;
    load_final   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        scr_next = cs;
        if (is_open) begin
          if (count < DEPTH_C) begin
            pair_we    = 1'b1;
            script_we  = 1'b1;
            count_next = count + CW'(1);
          end
          state_next = S_DECIDE;
        end else if (is_close && count != '0) begin
          state_next = S_POP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_POP: begin
        if (rd_pair == {pidx[PAIR_W-1:1], 1'b0}) begin
          scr_next   = rd_script;
          mark_next  = (mark < count) ? mark : count;
          state_next = S_DECIDE;
        end else begin
          count_next = cnt_m1;
          if (count == CW'(1)) begin
            mark_next  = '0;
            state_next = S_DECIDE;
          end else begin
            rd_addr = cnt_m2[AW-1:0];
          end
        end
      end
      S_DECIDE: begin
        if (!rr || !r || scr == running) begin
          state_next = S_FIN;
          if (!rr && r) begin
            running_next = scr;
            if (mark < count) begin
              state_next = S_FILL;
            end
          end
        end else begin
          mark_next  = count;
          state_next = S_EMITB;
        end
      end
      S_FILL: begin
        script_we = 1'b1;
        wr_addr   = mark[AW-1:0];
        wr_script = scr;
        mark_next = mark + CW'(1);
        if (mark + CW'(1) == count) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (is_close && count != '0) begin
          count_next = cnt_m1;
          if (mark > cnt_m1) begin
            mark_next = cnt_m1;
          end
        end
        length_next = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
        state_next  = eot ? S_EMITF : S_IDLE;
      end
      S_EMITB: begin
        if (out_free) begin
          load_out     = 1'b1;
          running_next = common_code;
          length_next  = '0;
          state_next   = S_EVAL;
        end
      end
      S_EMITF: begin
        if (out_free) begin
          load_out     = 1'b1;
          load_final   = 1'b1;
          running_next = common_code;
          length_next  = '0;
          count_next   = '0;
          mark_next    = '0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      running        <= '0;
      length         <= '0;
      count          <= '0;
      mark           <= '0;
      out_valid      <= 1'b0;
      common_code    <= 8'd0;
      inherited_code <= 8'd1;
    end else begin
      state   <= state_next;
      running <= running_next;
      length  <= length_next;
      count   <= count_next;
      mark    <= mark_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_COMMON) begin
          common_code <= pwdata[7:0];
        end else begin
          inherited_code <= pwdata[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scr <= scr_next;
    if (state == S_IDLE && in_valid) begin
      cs        <= char_script;
      eot       <= end_of_text;
      two_units <= (code_point[20:16] != '0);
      pidx      <= br.idx;
      is_open   <= br.found && (char_script == common_code) && !br.idx[0];
      is_close  <= br.found && (char_script == common_code) && br.idx[0];
    end
    if (load_out) begin
      run_script <= running;
      run_units  <= length;
      final_run  <= load_final;
    end
  end

endmodule
